FILE: hw/rtl/scalu_pkg.sv
package scalu_pkg;

    // opcode codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_GMA = 2'd3
    } t_scalu_op;

    typedef struct packed {
        t_scalu_op          opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] operand_c;
    } t_scalu_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               is_error;
    } t_scalu_rsp;

    // error sentinel and safe range
    localparam logic signed [31:0] SENT_VAL = 32'sh8000_0000;
    localparam logic signed [31:0] SAFE_HI  = 32'sh7FFF_FFFE;
    localparam logic signed [31:0] SAFE_LO  = 32'sh8000_0001;

endpackage

FILE: hw/rtl/sentinel_checked_int32_alu_core.sv
// a request passes stages 1 to 4 to reach o_out_valid, delayed only while the output stalls
// one request per cycle unless the output stalls; four stages, each with a valid bit
// the 32x32 multiply shares stage 2 with the raw sum; range checks and final add follow it
// stalls collapse bubbles stage by stage, so a waiting result blocks new requests
// only once all four stages hold a request
// reset (i_rst_n low, synchronous) clears every stage valid bit; data registers are not reset
module sentinel_checked_int32_alu_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  scalu_pkg::t_scalu_req  i_in_req,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output scalu_pkg::t_scalu_rsp  o_out_rsp
);
    import scalu_pkg::*;

    // stage valid bits and per-stage advance enables
    logic [3:0] r_v;
    logic       en1, en2, en3, en4;

    assign en4 = !r_v[3] || i_out_ready;
    assign en3 = !r_v[2] || en4;
    assign en2 = !r_v[1] || en3;
    assign en1 = !r_v[0] || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_v[3];

    // stage 1: registered request plus sentinel flags
    t_scalu_op          r1_op;
    logic signed [31:0] r1_a, r1_b, r1_c;
    logic               r1_a_s, r1_b_s, r1_c_s, r1_nb_bad;

    // stage 2: raw sum and raw product
    t_scalu_op          r2_op;
    logic signed [33:0] r2_sum;
    logic               r2_add_err;
    logic signed [63:0] r2_prod;
    logic               r2_mul_err;
    logic signed [31:0] r2_c;
    logic               r2_c_s;

    // stage 3: range-checked first result
    t_scalu_op          r3_op;
    logic signed [31:0] r3_val;
    logic               r3_err;
    logic signed [31:0] r3_c;
    logic               r3_c_s;

    // stage 4: output register
    t_scalu_rsp         r4_rsp;

    logic signed [32:0] n_addend;
    logic signed [33:0] n_sum;
    logic               n_add_err;
    logic signed [31:0] n3_val;
    logic               n3_err;
    logic signed [32:0] n4_sum;
    logic               n4_err;
    logic signed [31:0] n4_val;

    // subtract adds the negated b; b = -2^31+1 is rejected outright
    always_comb begin
        n_addend = (r1_op == OP_SUB) ? (33'sd0 - {r1_b[31], r1_b}) : {r1_b[31], r1_b};
        n_sum    = {r1_a[31], r1_a[31], r1_a} + {n_addend[32], n_addend};
        n_add_err = r1_a_s || r1_b_s || ((r1_op == OP_SUB) && r1_nb_bad);
    end

    // range checks; a zero factor gives a zero product, which is in range
    always_comb begin
        if (r2_op == OP_ADD || r2_op == OP_SUB) begin
            n3_err = r2_add_err
                || (r2_sum > $signed({{2{SAFE_HI[31]}}, SAFE_HI}))
                || (r2_sum < $signed({{2{SAFE_LO[31]}}, SAFE_LO}));
            n3_val = r2_sum[31:0];
        end else begin
            n3_err = r2_mul_err
                || (r2_prod > $signed({{32{SAFE_HI[31]}}, SAFE_HI}))
                || (r2_prod < $signed({{32{SAFE_LO[31]}}, SAFE_LO}));
            n3_val = r2_prod[31:0];
        end
    end

    // gated op: add c to the checked product
    always_comb begin
        n4_sum = {r3_val[31], r3_val} + {r3_c[31], r3_c};
        if (r3_op == OP_GMA) begin
            n4_err = r3_err || r3_c_s
                || (n4_sum > $signed({SAFE_HI[31], SAFE_HI}))
                || (n4_sum < $signed({SAFE_LO[31], SAFE_LO}));
            n4_val = n4_sum[31:0];
        end else begin
            n4_err = r3_err;
            n4_val = r3_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'b0000;
        end else begin
            if (en1) r_v[0] <= i_in_valid;
            if (en2) r_v[1] <= r_v[0];
            if (en3) r_v[2] <= r_v[1];
            if (en4) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_op     <= i_in_req.opcode;
            r1_a      <= i_in_req.operand_a;
            r1_b      <= i_in_req.operand_b;
            r1_c      <= i_in_req.operand_c;
            r1_a_s    <= (i_in_req.operand_a == SENT_VAL);
            r1_b_s    <= (i_in_req.operand_b == SENT_VAL);
            r1_c_s    <= (i_in_req.operand_c == SENT_VAL);
            r1_nb_bad <= (i_in_req.operand_b == SAFE_LO);
        end
        if (en2) begin
            r2_op      <= r1_op;
            r2_sum     <= n_sum;
            r2_add_err <= n_add_err;
            r2_prod    <= r1_a * r1_b;
            r2_mul_err <= r1_a_s || r1_b_s;
            r2_c       <= r1_c;
            r2_c_s     <= r1_c_s;
        end
        if (en3) begin
            r3_op  <= r2_op;
            r3_val <= n3_val;
            r3_err <= n3_err;
            r3_c   <= r2_c;
            r3_c_s <= r2_c_s;
        end
        if (en4) begin
            r4_rsp.result_value <= n4_err ? SENT_VAL : n4_val;
            r4_rsp.is_error     <= n4_err;
        end
    end

    assign o_out_rsp = r4_rsp;

endmodule

FILE: hw/rtl/scalu_checker.sv
module scalu_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input scalu_pkg::t_scalu_req i_in_req,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input scalu_pkg::t_scalu_rsp o_out_rsp
);
    import scalu_pkg::*;

    // waiting request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_req))
        else $error("waiting request changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled result changed");

    // error flag matches sentinel value
    a_flag_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.is_error == (o_out_rsp.result_value == SENT_VAL)))
        else $error("error flag and sentinel disagree");

    // pipe empties on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // free output implies a free input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("request blocked while output is free");

endmodule

bind sentinel_checked_int32_alu_core scalu_checker u_scalu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);
